>>> hdl/bfm_pkg.sv
package bfm_pkg;

  // operand and product width, fixed by the interface
  localparam int FIELD_BITS = 63;
  // width of the reduction polynomial register
  localparam int WORD_BITS = 64;
  // one step per bit of operand_b
  localparam int NUM_STEPS = FIELD_BITS;
  // shift-and-add steps done in each pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES = (NUM_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

endpackage

>>> hdl/bfm_cfg.sv
module bfm_cfg #(
  parameter int MAX_DEGREE = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          reduction_poly_write,
  input  logic [bfm_pkg::WORD_BITS-1:0] reduction_poly,
  output logic [MAX_DEGREE:0]           poly,
  output logic [MAX_DEGREE-1:0]         hi_mask,
  output logic [MAX_DEGREE-1:0]         low_mask,
  output logic                          bypass
);
  import bfm_pkg::*;

  localparam int PW = MAX_DEGREE + 1;

  logic [PW-1:0] masked;
  logic [PW-1:0] smear;
  logic [PW-1:0] top;
  logic [PW-1:0] top_minus;

  // isolate the highest set bit: smear it down, then keep the edge
  always_comb begin
    masked = reduction_poly[MAX_DEGREE:0];
    smear  = masked;
    for (int i = 0; i < $clog2(PW); i++) begin
      smear = smear | (smear >> (1 << i));
    end
    top       = smear ^ (smear >> 1);
    top_minus = top - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly     <= '0;
      hi_mask  <= '0;
      low_mask <= '1;
      bypass   <= 1'b1;
    end else if (reduction_poly_write) begin
      poly     <= masked;
      hi_mask  <= top[MAX_DEGREE:1];
      low_mask <= top_minus[MAX_DEGREE-1:0];
      bypass   <= (masked[MAX_DEGREE:1] == '0);
    end
  end

endmodule

>>> hdl/bfm_stage.sv
module bfm_stage #(
  parameter int MAX_DEGREE = 63,
  parameter int STEPS      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [MAX_DEGREE:0]            poly,
  input  logic [MAX_DEGREE-1:0]          hi_mask,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfm_pkg::FIELD_BITS-1:0] in_acc,
  input  logic [MAX_DEGREE-1:0]          in_c,
  input  logic [bfm_pkg::FIELD_BITS-1:0] in_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfm_pkg::FIELD_BITS-1:0] out_acc,
  output logic [MAX_DEGREE-1:0]          out_c,
  output logic [bfm_pkg::FIELD_BITS-1:0] out_b
);
  import bfm_pkg::*;

  logic [FIELD_BITS-1:0] acc_w;
  logic [MAX_DEGREE-1:0] c_w;
  logic [FIELD_BITS-1:0] b_w;
  logic [MAX_DEGREE:0]   c_ext;
  logic                  hit;

  // b is consumed from bit 0 and shifted down one place per step
  always_comb begin
    acc_w = in_acc;
    c_w   = in_c;
    b_w   = in_b;
    c_ext = '0;
    hit   = 1'b0;
    for (int j = 0; j < STEPS; j++) begin
      if (b_w[0]) begin
        acc_w = acc_w ^ FIELD_BITS'(c_w);
      end
      hit   = |(c_w & hi_mask);
      c_ext = {c_w, 1'b0} ^ (hit ? poly : '0);
      c_w   = c_ext[MAX_DEGREE-1:0];
      b_w   = b_w >> 1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_acc <= acc_w;
      out_c   <= c_w;
      out_b   <= b_w;
    end
  end

endmodule

>>> hdl/binary_field_multiply.sv
// GF(2^m) shift-and-add multiplier, sixteen register stages: four steps each, three in the last.
// A word accepted at the input moves through the stage registers in order,
//   and the last stage's register is the output; the last stage does three steps.
// Throughput: one word per cycle unless stalled; with a valid bit per stage, bubbles close up.
// Reset (rst, synchronous, active high) empties every stage and clears the
//   reduction polynomial to zero, which passes operand_a through.
module binary_field_multiply #(
  parameter int MAX_DEGREE = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          reduction_poly_write,
  input  logic [bfm_pkg::WORD_BITS-1:0] reduction_poly,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfm_pkg::FIELD_BITS-1:0] operand_a,
  input  logic [bfm_pkg::FIELD_BITS-1:0] operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfm_pkg::FIELD_BITS-1:0] product
);
  import bfm_pkg::*;

  // derived config: polynomial, bit m-1 as a one-hot probe, mask below m
  logic [MAX_DEGREE:0]   poly;
  logic [MAX_DEGREE-1:0] hi_mask;
  logic [MAX_DEGREE-1:0] low_mask;
  logic                  bypass;

  // chain index s is the input of stage s; index NUM_STAGES is the output
  logic [NUM_STAGES:0]   valid_chain;
  logic [NUM_STAGES:0]   ready_chain;
  logic [FIELD_BITS-1:0] acc_chain [NUM_STAGES+1];
  logic [MAX_DEGREE-1:0] c_chain   [NUM_STAGES+1];
  logic [FIELD_BITS-1:0] b_chain   [NUM_STAGES+1];

  bfm_cfg #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_cfg (
    .clk                 (clk),
    .rst                 (rst),
    .reduction_poly_write(reduction_poly_write),
    .reduction_poly      (reduction_poly),
    .poly                (poly),
    .hi_mask             (hi_mask),
    .low_mask            (low_mask),
    .bypass              (bypass)
  );

  // Entry: a is reduced below degree m. For a polynomial of degree zero or
  // unset, the accumulator starts as a and b is zeroed, so nothing is added.
  assign valid_chain[0] = in_valid;
  assign in_ready       = ready_chain[0];
  assign acc_chain[0]   = bypass ? operand_a : '0;
  assign c_chain[0]     = operand_a[MAX_DEGREE-1:0] & low_mask;
  assign b_chain[0]     = bypass ? '0 : operand_b;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int Left  = NUM_STEPS - s * STEPS_PER_STAGE;
    localparam int Steps = (Left < STEPS_PER_STAGE) ? Left : STEPS_PER_STAGE;

    bfm_stage #(
      .MAX_DEGREE(MAX_DEGREE),
      .STEPS     (Steps)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .poly     (poly),
      .hi_mask  (hi_mask),
      .in_valid (valid_chain[s]),
      .in_ready (ready_chain[s]),
      .in_acc   (acc_chain[s]),
      .in_c     (c_chain[s]),
      .in_b     (b_chain[s]),
      .out_valid(valid_chain[s+1]),
      .out_ready(ready_chain[s+1]),
      .out_acc  (acc_chain[s+1]),
      .out_c    (c_chain[s+1]),
      .out_b    (b_chain[s+1])
    );
  end

  // last stage register is the output register
  assign ready_chain[NUM_STAGES] = out_ready;
  assign out_valid               = valid_chain[NUM_STAGES];
  assign product                 = acc_chain[NUM_STAGES];

`ifndef SYNTHESIS
  // every bit of b has been consumed by the time a word leaves
  a_b_consumed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (b_chain[NUM_STAGES] == '0))
    else $error("operand_b bits left over at output");

  // the running multiple stays reduced below degree m
  a_c_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((c_chain[NUM_STAGES] & ~low_mask) == '0))
    else $error("running multiple not reduced");

  // input is held off only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&valid_chain[NUM_STAGES:1]) && !out_ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> sim/binary_field_multiply_test.sv
`timescale 1ns / 1ps

module binary_field_multiply_test;
  import bfm_pkg::*;

  // Pipeline depth of the DUT; drain() waits on it so the pipe can settle.
  localparam int LATENCY = 16;
  localparam int MAX_DEGREE = 63;
  localparam logic [WORD_BITS-1:0] POLY_MASK =
    (MAX_DEGREE >= WORD_BITS - 1) ? '1 : ((64'd2 << MAX_DEGREE) - 64'd1);
  localparam logic [FIELD_BITS-1:0] ONES = '1;
  localparam logic [FIELD_BITS-1:0] TOP_BIT = {1'b1, {(FIELD_BITS - 1){1'b0}}};

  typedef struct {
    logic [FIELD_BITS-1:0] a;
    logic [FIELD_BITS-1:0] b;
    logic [WORD_BITS-1:0]  poly;
    logic [FIELD_BITS-1:0] product;
  } product_entry_t;

  // All DUT inputs start at known values.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  reduction_poly_write = 1'b0;
  logic [WORD_BITS-1:0]  reduction_poly = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FIELD_BITS-1:0] operand_a = '0;
  logic [FIELD_BITS-1:0] operand_b = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FIELD_BITS-1:0] product;

  // Predictor copy of the one config register.
  logic [WORD_BITS-1:0] current_poly = '0;
  // Products still owed by the DUT, oldest first.
  product_entry_t expected_products[$];

  int failures = 0;
  int mismatches = 0;
  // Set by a test to make the sink hold off; consumed by the sink process.
  int hold_off_cycles = 0;
  // When set, that side never idles between words.
  bit steady_source = 1'b0;
  bit steady_sink = 1'b0;

  binary_field_multiply #(
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .reduction_poly_write(reduction_poly_write),
    .reduction_poly(reduction_poly),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .product(product)
  );

  always #2 clk = ~clk;

  // Position of the highest set bit, -1 for an empty polynomial.
  function automatic int poly_degree(input logic [WORD_BITS-1:0] p);
    int d;
    int k;
    d = -1;
    for (k = 0; k < WORD_BITS; k++) begin
      if (p[k]) d = k;
    end
    return d;
  endfunction

  // Shift-and-add GF(2^m) product. Degree below one passes a through.
  function automatic logic [FIELD_BITS-1:0] gf_product(input logic [FIELD_BITS-1:0] a,
                                                       input logic [FIELD_BITS-1:0] b,
                                                       input logic [WORD_BITS-1:0] poly);
    logic [WORD_BITS-1:0] p;
    logic [WORD_BITS-1:0] top;
    logic [WORD_BITS-1:0] c;
    logic [WORD_BITS-1:0] acc;
    int m;
    int k;
    p = poly & POLY_MASK;
    m = poly_degree(p);
    if (m <= 0) return a;
    top = 64'd1 << m;
    // operand a is reduced first: bits at or above m drop out
    c = {1'b0, a} & (top - 64'd1);
    acc = '0;
    // every bit of b is used, even those above m
    for (k = 0; k < FIELD_BITS; k++) begin
      if (b[k]) acc ^= c;
      c = c << 1;
      if ((c & top) != 0) c ^= p;
    end
    return acc[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_field();
    logic [WORD_BITS-1:0] r;
    r = {$urandom, $urandom};
    return r[FIELD_BITS-1:0];
  endfunction

  // Random irreducible-looking polynomial: odd, degree weighted toward the extremes.
  function automatic logic [WORD_BITS-1:0] draw_poly();
    int d;
    logic [WORD_BITS-1:0] low;
    case ($urandom_range(0, 7))
      0: begin
        d = 63;
      end
      1: begin
        d = $urandom_range(1, 4);
      end
      default: begin
        d = $urandom_range(2, 63);
      end
    endcase
    low = {$urandom, $urandom};
    return (low & ((64'd1 << d) - 64'd1)) | (64'd1 << d) | 64'd1;
  endfunction

  // Operand mix: mostly full random (unreduced), plus corners and reduced values.
  function automatic logic [FIELD_BITS-1:0] pick_operand(input int m);
    logic [WORD_BITS-1:0] mask;
    mask = (m <= 0) ? '1 : ((64'd1 << m) - 64'd1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      2: return TOP_BIT >> $urandom_range(0, FIELD_BITS - 1);
      3: return rand_field() & mask[FIELD_BITS-1:0];
      default: return rand_field();
    endcase
  endfunction

  // Drive one word; returns at the edge that accepts it.
  task automatic send_word(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b);
    int gap;
    product_entry_t entry;
    gap = steady_source ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    entry.a = a;
    entry.b = b;
    entry.poly = current_poly;
    entry.product = gf_product(a, b, current_poly);
    expected_products = {expected_products, entry};
  endtask

  // Drop valid, wait for every owed product, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Only called with the pipe empty.
  task automatic set_poly(input logic [WORD_BITS-1:0] value);
    reduction_poly_write <= 1'b1;
    reduction_poly <= value;
    @(posedge clk);
    reduction_poly_write <= 1'b0;
    current_poly = value;
  endtask

  // Unset polynomial (reset value) and degree zero both pass a through.
  task automatic test_pass_through();
    send_word('0, '0);
    send_word(ONES, ONES);
    send_word(TOP_BIT, 63'd5);
    drain();
    set_poly(64'd1);
    send_word(ONES, '0);
    send_word(rand_field(), rand_field());
    drain();
  endtask

  // Largest and smallest degrees, unreduced a, b bits above m.
  task automatic test_field_extremes();
    set_poly(64'h8000_0000_0000_0003);
    send_word(ONES, ONES);
    send_word(63'd1, TOP_BIT);
    send_word(TOP_BIT, TOP_BIT);
    send_word('0, ONES);
    send_word(ONES, '0);
    send_word(TOP_BIT, 63'd1);
    drain();
    // x + 1: a keeps only bit 0
    set_poly(64'h3);
    send_word(ONES, ONES);
    send_word(63'd2, 63'd1);
    send_word(63'd1, TOP_BIT);
    drain();
    // x^4 + x + 1 with wide operands
    set_poly(64'h13);
    send_word(ONES, 63'h5a5a_5a5a_5a5a_5a5a);
    send_word(63'd3, TOP_BIT);
    send_word(63'd5, 63'd7);
    drain();
    // every register bit set
    set_poly('1);
    send_word(ONES, ONES);
    send_word(TOP_BIT, 63'd2);
    drain();
  endtask

  // Phases of random words, one polynomial each, with varying idle patterns.
  task automatic test_random_products();
    int phase;
    int n;
    int m;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          set_poly(64'h8000_0000_0000_001b);
        end
        1: begin
          set_poly(64'h3);
        end
        default: begin
          set_poly(draw_poly());
        end
      endcase
      m = poly_degree(current_poly);
      steady_source = (phase == 3) || (phase == 5);
      steady_sink = (phase == 4) || (phase == 5);
      for (n = 0; n < 100; n++) begin
        send_word(pick_operand(m), pick_operand(m));
      end
      drain();
    end
    steady_source = 1'b0;
    steady_sink = 1'b0;
  endtask

  // Sink stalls for a long stretch while the source streams without gaps.
  task automatic test_back_pressure();
    int n;
    int m;
    set_poly(draw_poly());
    m = poly_degree(current_poly);
    steady_source = 1'b1;
    hold_off_cycles = 80;
    for (n = 0; n < 60; n++) begin
      send_word(pick_operand(m), pick_operand(m));
    end
    drain();
    steady_source = 1'b0;
  endtask

  // Sink: a random stall before each word, plus any long hold a test asks for.
  initial begin : sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = steady_sink ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Checker: each product taken is matched against the oldest owed one.
  always @(posedge clk) begin : check_products
    product_entry_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_products.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected product word %h", product);
      end else begin
        want = expected_products.pop_front();
        if (product !== want.product) begin
          failures++;
          mismatches++;
          if (mismatches <= 10)
            $display("product mismatch: a=%h b=%h poly=%h expected %h got %h",
                     want.a, want.b, want.poly, want.product, product);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pass_through();
    test_field_extremes();
    test_random_products();
    test_back_pressure();
    if (failures == 0) begin
      $display("binary_field_multiply_test passed");
    end else begin
      $display("binary_field_multiply_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("binary_field_multiply_test failed");
    $finish;
  end

endmodule
